// ----- sv/hte_pkg.sv -----
// Package for the hash table engine: sizes, request and status codes, states.
// Used by hte_hash_unit and hash_table_engine.
`default_nettype none
package hte_pkg;
  localparam int NUM_BUCKETS = 256;
  localparam int WAYS        = 4;
  localparam int KEY_BYTES   = 8;
  localparam int VALUE_BITS  = 32;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W       = 11;
  localparam int TS_W        = 9;
  localparam int KL_W        = 4;
  localparam int DIV_W       = 17;
  localparam logic [63:0] HASH_INIT = 64'd5381;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_READ, S_SCAN, S_WRITE, S_CLEAR
  } state_e;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;
endpackage
`default_nettype wire

// ----- sv/hte_hash_unit.sv -----
// Byte-serial djb2 hash followed by a bit-serial modulo by the table size.
// Depends on hte_pkg.
`default_nettype none
module hte_hash_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [63:0]              key_i,
  input  wire logic [3:0]               nbytes_i,
  input  wire logic [hte_pkg::TS_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [hte_pkg::BKT_W-1:0]     bucket_o
);
  import hte_pkg::*;

  logic [63:0]      h_q, h_d;
  logic [63:0]      key_q, key_d;
  logic [3:0]       left_q, left_d;
  logic [6:0]       bit_q, bit_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [TS_W-1:0]  div_q, div_d;
  logic [1:0]       ph_q, ph_d;
  logic [DIV_W-1:0] trial;

  always_comb begin
    h_d = h_q; key_d = key_q; left_d = left_q; bit_d = bit_q;
    rem_d = rem_q; div_d = div_q; ph_d = ph_q;
    trial = {rem_q[DIV_W-2:0], h_q[63]};
    case (ph_q)
      2'd0: if (start_i) begin
        h_d = HASH_INIT; key_d = key_i; left_d = nbytes_i;
        div_d = divisor_i; ph_d = 2'd1;
      end
      2'd1: begin
        if (left_q == 4'd0) begin
          ph_d = 2'd2; bit_d = 7'd0; rem_d = '0;
        end else begin
          h_d = (h_q << 5) + h_q + {56'd0, key_q[7:0]};
          key_d = key_q >> 8;
          left_d = left_q - 4'd1;
        end
      end
      2'd2: begin
        rem_d = (trial >= {{(DIV_W-TS_W){1'b0}}, div_q}) ?
                trial - {{(DIV_W-TS_W){1'b0}}, div_q} : trial;
        h_d = h_q << 1;
        bit_d = bit_q + 7'd1;
        if (bit_q == 7'd63) ph_d = 2'd3;
      end
      default: ph_d = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= 2'd0;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; key_q <= key_d; left_q <= left_d; bit_q <= bit_d;
    rem_q <= rem_d; div_q <= div_d;
  end

  assign done_o   = (ph_q == 2'd3);
  assign bucket_o = rem_q[BKT_W-1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rem_q < {{(DIV_W-TS_W){1'b0}}, div_q})
    else $error("remainder not below divisor");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> ph_q == 2'd0)
    else $error("hash unit did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == 2'd1) |-> left_q <= 4'd8)
    else $error("byte count out of range");
endmodule
`default_nettype wire

// ----- sv/hash_table_engine.sv -----
// Top level of the hash table engine: request control, slot memories, counts.
// Depends on hte_pkg and hte_hash_unit.
//
// Usage: a request (req_type_i, key_i, value_i) is taken when req_valid_i is
// high and req_stall_o low. One request is in work at a time. The hash runs
// over key_length bytes, then the modulo takes one quotient bit a cycle and
// signals done; then the bucket's WAYS slots are read one a cycle from the
// slot memories (one read port, registered read) and at most one slot is
// written back. The next request can be taken as the result appears.
// The result (status_o, value_out_o, item_count_o) sits in an output
// register while res_valid_o is high; res_stall_i holds it in place. The
// engine takes the next request meanwhile and holds it before its write-back
// until the output register is free. After reset a clearing pass over all
// NUM_BUCKETS*WAYS slots (1024) clears every valid bit with req_stall_o
// high; the item count resets to zero, table_size to 256 and key_length to 8.
// Configuration writes use cfg_we_i, cfg_idx_i, cfg_data_i; the user must make
// them while no request is in flight, as the engine does not enforce this.
`default_nettype none
module hash_table_engine (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [hte_pkg::TS_W-1:0]       cfg_data_i,
  input  wire logic                           req_valid_i,
  output logic                                req_stall_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [63:0]                    key_i,
  input  wire logic [31:0]                    value_i,
  output logic                                res_valid_o,
  input  wire logic                           res_stall_i,
  output logic [2:0]                          status_o,
  output logic [31:0]                         value_out_o,
  output logic [hte_pkg::CNT_W-1:0]           item_count_o
);
  import hte_pkg::*;

  localparam int SLOTS  = NUM_BUCKETS * WAYS;
  localparam int SLOT_W = $clog2(SLOTS);

  state_e st_q, st_d;
  logic [TS_W-1:0]  ts_q;
  logic [KL_W-1:0]  kl_q;
  logic [1:0]       req_q;
  logic [63:0]      key_q, km_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [BKT_W-1:0] bkt_q;
  logic [WAY_W:0]   way_q;
  logic             hit_q, free_q;
  logic [WAY_W-1:0] hitw_q, freew_q;
  logic [VALUE_BITS-1:0] hitv_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SLOT_W-1:0] clr_q;
  logic [2:0]       stat_q;
  logic [31:0]      vout_q;
  logic             res_valid_q;

  logic [63:0]           mkey [SLOTS];
  logic [VALUE_BITS-1:0] mval [SLOTS];
  logic                  mvld [SLOTS];
  logic [63:0]           rkey_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic                  rvld_q;
  logic [SLOT_W-1:0]     raddr, waddr, prev_addr;
  logic                  we_key, we_val, we_vld, vld_wd;

  logic [3:0]       kl_eff;
  logic [TS_W-1:0]  ts_eff;
  logic             h_done;
  logic [BKT_W-1:0] h_bkt;
  logic             accept, scan_last, out_free, wr_go;

  assign kl_eff = (kl_q == 4'd0) ? 4'd1 : (kl_q > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : kl_q;
  assign ts_eff = (ts_q == '0) ? TS_W'(1) :
                  (ts_q > TS_W'(NUM_BUCKETS)) ? TS_W'(NUM_BUCKETS) : ts_q;
  assign accept      = req_valid_i && !req_stall_o;
  assign req_stall_o = (st_q != S_IDLE);
  assign out_free    = !res_valid_q || !res_stall_i;
  assign wr_go       = (st_q == S_WRITE) && out_free;

  hte_hash_unit u_hash (
    .clk_i, .rst_ni, .start_i(accept), .key_i(key_i), .nbytes_i(kl_eff),
    .divisor_i(ts_eff), .done_o(h_done), .bucket_o(h_bkt)
  );

  assign raddr     = SLOT_W'({bkt_q, way_q[WAY_W-1:0]} & {(BKT_W+WAY_W){1'b1}});
  assign prev_addr = SLOT_W'({bkt_q, WAY_W'(way_q - 1'b1)});
  assign scan_last = (way_q == (WAY_W+1)'(WAYS));

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (accept) st_d = S_HASH;
      S_HASH:  if (h_done) st_d = S_READ;
      S_READ:  st_d = S_SCAN;
      S_SCAN:  if (scan_last) st_d = S_WRITE;
      S_WRITE: if (out_free) st_d = S_IDLE;
      S_CLEAR: if (clr_q == SLOT_W'(SLOTS - 1)) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    we_key = 1'b0;
    we_val = 1'b0;
    we_vld = 1'b0;
    vld_wd = 1'b0;
    waddr  = SLOT_W'({bkt_q, hitw_q});
    if (st_q == S_CLEAR) begin
      we_vld = 1'b1;
      waddr  = clr_q;
    end else if (wr_go) begin
      case (req_q)
        REQ_INSERT: begin
          if (hit_q) we_val = 1'b1;
          else if (free_q) begin
            we_key = 1'b1; we_val = 1'b1; we_vld = 1'b1; vld_wd = 1'b1;
            waddr = SLOT_W'({bkt_q, freew_q});
          end
        end
        REQ_DELETE: if (hit_q) we_vld = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_q <= mkey[raddr];
    rval_q <= mval[raddr];
    rvld_q <= mvld[raddr];
    if (we_key) mkey[waddr] <= key_q;
    if (we_val) mval[waddr] <= val_q;
    if (we_vld) mvld[waddr] <= vld_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; ts_q <= TS_W'(256); kl_q <= 4'd8; cnt_q <= '0;
      clr_q <= '0; res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TABLE_SIZE) ts_q <= cfg_data_i;
        else kl_q <= cfg_data_i[KL_W-1:0];
      end
      if (wr_go) begin
        res_valid_q <= 1'b1;
        if (req_q == REQ_INSERT && !hit_q && free_q) begin
          cnt_q <= cnt_q + 1'b1;
        end else if (req_q == REQ_DELETE && hit_q) begin
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        end
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i; key_q <= key_i; val_q <= value_i[VALUE_BITS-1:0];
      km_q  <= (kl_eff >= 4'd8) ? '1 : ((64'd1 << {kl_eff, 3'd0}) - 64'd1);
    end
    if (h_done) begin
      bkt_q <= h_bkt; way_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
    end
    if (st_q == S_READ) way_q <= way_q + 1'b1;
    if (st_q == S_SCAN) begin
      if (!scan_last) way_q <= way_q + 1'b1;
      if (rvld_q) begin
        if (!hit_q && ((rkey_q ^ key_q) & km_q) == 64'd0) begin
          hit_q <= 1'b1; hitw_q <= prev_addr[WAY_W-1:0]; hitv_q <= rval_q;
        end
      end else if (!free_q) begin
        free_q <= 1'b1; freew_q <= prev_addr[WAY_W-1:0];
      end
    end
    if (wr_go) begin
      vout_q <= '0;
      case (req_q)
        REQ_INSERT: stat_q <= hit_q ? ST_UPDATED : free_q ? ST_INSERTED : ST_FULL;
        REQ_SEARCH: begin
          stat_q <= hit_q ? ST_FOUND : ST_NOT_FOUND;
          if (hit_q) vout_q <= 32'(hitv_q);
        end
        REQ_DELETE: stat_q <= hit_q ? ST_DELETED : ST_NOT_FOUND;
        default:    stat_q <= ST_NOT_FOUND;
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign status_o     = stat_q;
  assign value_out_o  = vout_q;
  assign item_count_o = cnt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_stall_i) |=> res_valid_o && $stable(status_o) &&
      $stable(value_out_o) && $stable(item_count_o))
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_key || we_val) |-> st_q == S_WRITE)
    else $error("slot write outside write state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOTS))
    else $error("item count above slot count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLEAR) |-> !res_valid_o)
    else $error("result during clearing pass");
endmodule
`default_nettype wire
